/* hdl/cbm_pkg.sv */
`timescale 1ns / 1ps

package cbm_pkg;

    // Bus event codes carried in the cmd field.
    localparam logic [2:0] CMD_PRG_READ  = 3'd0;
    localparam logic [2:0] CMD_PRG_WRITE = 3'd1;
    localparam logic [2:0] CMD_VID_READ  = 3'd2;
    localparam logic [2:0] CMD_VID_WRITE = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;

    // Target memory codes of a result word.
    localparam logic [2:0] TGT_NONE      = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM   = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM   = 3'd2;
    localparam logic [2:0] TGT_READ_ZERO = 3'd3;
    localparam logic [2:0] TGT_CHR_ROM   = 3'd4;
    localparam logic [2:0] TGT_CHR_RAM   = 3'd5;
    localparam logic [2:0] TGT_NAMETABLE = 3'd6;

    // Character memory kinds held in the configuration register.
    localparam logic [1:0] CHR_KIND_NONE  = 2'd0;
    localparam logic [1:0] CHR_KIND_ROM   = 2'd1;
    localparam logic [1:0] CHR_KIND_RAM   = 2'd2;
    localparam logic [1:0] CHR_KIND_RESET = CHR_KIND_ROM;

    // Mapper register decode, taken on address & REG_DECODE_MASK.
    localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [15:0] REG_MIRRORING   = 16'hA000;
    localparam logic [15:0] REG_RAM_PROTECT = 16'hA001;
    localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
    localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;

    // Fixed program banks.
    localparam logic [5:0] PRG_BANK_SECOND_LAST = 6'h3E;
    localparam logic [5:0] PRG_BANK_LAST        = 6'h3F;

    // Edge filter length in ticks.
    localparam logic [2:0] EDGE_FILTER_TICKS = 3'd6;

    // One input word.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [2:0]  target;
        logic [18:0] mapped_address;
        logic        irq_out;
    } t_out_word;

endpackage

/* hdl/cbm_ifs.sv */
`timescale 1ns / 1ps

// Input channel: bus events.
interface cbm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, output cmd, output address, output data, input ready);
    modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

// Output channel: mapped accesses.
interface cbm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [18:0] mapped_address;
    logic        irq_out;

    modport source (output valid, output target, output mapped_address, output irq_out,
                    input ready);
    modport sink   (input valid, input target, input mapped_address, input irq_out,
                    output ready);
endinterface

// Configuration write channel: character memory kind.
interface cbm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/cartridge_bank_mapper_scanline_irq.sv */
`timescale 1ns / 1ps

// Cartridge bank mapper with a scanline interrupt counter. Each input word is a
// program read or write, a video read or write, or a tick, and each gives exactly
// one result word: the target memory, the address inside it and the interrupt
// level after the event. A word is taken in every cycle in which the output
// register is empty or is being emptied, so the sustained rate is one word per
// cycle while the output is ready, and its result appears in the cycle after
// acceptance; the only path is the decode and counter logic up to the output register.
// The configuration channel, always ready, sets the character memory kind and
// should be written only while no word is in flight.
module cartridge_bank_mapper_scanline_irq (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbm_in_if.sink     i_in,
    cbm_out_if.source  o_out,
    cbm_cfg_if.sink    i_cfg
);

    logic               accept;
    cbm_pkg::t_in_word  in_word;
    cbm_pkg::t_out_word result;
    cbm_pkg::t_out_word r_out;
    logic               r_out_valid;

    // Take a word whenever the output register can hold its result.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign in_word.cmd     = i_in.cmd;
    assign in_word.address = i_in.address;
    assign in_word.data    = i_in.data;

    cbm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (in_word),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_result   (result)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.target         = r_out.target;
    assign o_out.mapped_address = r_out.mapped_address;
    assign o_out.irq_out        = r_out.irq_out;

endmodule

/* hdl/cbm_core.sv */
`timescale 1ns / 1ps

module cbm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  cbm_pkg::t_in_word   i_word,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data,
    output cbm_pkg::t_out_word  o_result
);

    // Mapper state.
    logic [1:0] r_chr_kind,   n_chr_kind;
    logic       r_chr_mode,   n_chr_mode;
    logic       r_prg_mode,   n_prg_mode;
    logic       r_wram_en,    n_wram_en;
    logic [2:0] r_bank_index, n_bank_index;
    logic [5:0] r_prg_bank [2];
    logic [5:0] n_prg_bank [2];
    logic [7:0] r_chr_bank [6];
    logic [7:0] n_chr_bank [6];
    logic       r_mirror,     n_mirror;
    logic [1:0] r_read_ok,    n_read_ok;
    logic [1:0] r_write_ok,   n_write_ok;
    logic [7:0] r_irq_latch,  n_irq_latch;
    logic [7:0] r_irq_count,  n_irq_count;
    logic       r_irq_en,     n_irq_en;
    logic [2:0] r_filter,     n_filter;
    logic       r_irq_pend,   n_irq_pend;
    logic       r_last_a12,   n_last_a12;

    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [13:0] vaddr;
    logic [18:0] ram_addr;
    logic [18:0] chr_addr;
    logic [18:0] nt_addr;
    logic [18:0] rom_addr;
    logic [2:0]  slot;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_bank;
    logic [5:0]  rom_bank;
    logic        half;
    logic        a12_rise;

    assign addr  = i_word.address;
    assign wdata = i_word.data;
    assign vaddr = addr[13:0];
    assign half  = addr[9];

    // Program RAM: 1 KB mirrored over the window, halves picked by bit 9.
    assign ram_addr = {9'd0, addr[9:0]};

    // Program ROM: four 8 KB windows.
    always_comb begin
        case (addr[14:13])
            2'd0:    rom_bank = r_prg_mode ? cbm_pkg::PRG_BANK_SECOND_LAST : r_prg_bank[0];
            2'd1:    rom_bank = r_prg_bank[1];
            2'd2:    rom_bank = r_prg_mode ? r_prg_bank[0] : cbm_pkg::PRG_BANK_SECOND_LAST;
            default: rom_bank = cbm_pkg::PRG_BANK_LAST;
        endcase
    end
    assign rom_addr = {rom_bank, addr[12:0]};

    // Character map: two 2 KB slots and four 1 KB slots, halves swapped by mode.
    assign slot = vaddr[12:10] ^ {r_chr_mode, 2'b00};
    always_comb begin
        if (!slot[2]) begin
            chr_idx  = {2'b00, slot[1]};
            chr_bank = r_chr_bank[chr_idx];
            chr_addr = {1'b0, chr_bank, 10'd0} | {8'd0, vaddr[10:0]};
        end else begin
            chr_idx  = {1'b0, slot[1:0]} + 3'd2;
            chr_bank = r_chr_bank[chr_idx];
            chr_addr = {1'b0, chr_bank, vaddr[9:0]};
        end
    end

    // Nametable mirroring: bit 10 comes from bit 10 or bit 11.
    assign nt_addr = {8'd0, (r_mirror ? vaddr[11] : vaddr[10]), vaddr[9:0]};

    assign a12_rise = !r_last_a12 && vaddr[12];

    // Next state and result of the current word.
    always_comb begin
        n_chr_kind   = i_cfg_we ? i_cfg_data : r_chr_kind;
        n_chr_mode   = r_chr_mode;
        n_prg_mode   = r_prg_mode;
        n_wram_en    = r_wram_en;
        n_bank_index = r_bank_index;
        n_prg_bank   = r_prg_bank;
        n_chr_bank   = r_chr_bank;
        n_mirror     = r_mirror;
        n_read_ok    = r_read_ok;
        n_write_ok   = r_write_ok;
        n_irq_latch  = r_irq_latch;
        n_irq_count  = r_irq_count;
        n_irq_en     = r_irq_en;
        n_filter     = r_filter;
        n_irq_pend   = r_irq_pend;
        n_last_a12   = r_last_a12;
        o_result.target         = cbm_pkg::TGT_NONE;
        o_result.mapped_address = 19'd0;

        case (i_word.cmd)
            cbm_pkg::CMD_PRG_READ: begin
                if (addr[15:12] == 4'h7) begin
                    if (r_wram_en && (r_read_ok != 2'b00)) begin
                        if (r_read_ok[half]) begin
                            o_result.target         = cbm_pkg::TGT_PRG_RAM;
                            o_result.mapped_address = ram_addr;
                        end else begin
                            o_result.target = cbm_pkg::TGT_READ_ZERO;
                        end
                    end
                end else if (addr[15]) begin
                    o_result.target         = cbm_pkg::TGT_PRG_ROM;
                    o_result.mapped_address = rom_addr;
                end
            end
            cbm_pkg::CMD_PRG_WRITE: begin
                if (addr[15:12] == 4'h7) begin
                    if (r_wram_en && r_write_ok[half]) begin
                        o_result.target         = cbm_pkg::TGT_PRG_RAM;
                        o_result.mapped_address = ram_addr;
                    end
                end else if (addr[15]) begin
                    // Mapper register write.
                    case (addr & cbm_pkg::REG_DECODE_MASK)
                        cbm_pkg::REG_BANK_SELECT: begin
                            n_bank_index = wdata[2:0];
                            n_wram_en    = wdata[5];
                            n_prg_mode   = wdata[6];
                            n_chr_mode   = wdata[7];
                            if (!wdata[5]) begin
                                n_read_ok  = 2'b00;
                                n_write_ok = 2'b00;
                            end
                        end
                        cbm_pkg::REG_BANK_DATA: begin
                            if (r_bank_index < 3'd2) begin
                                n_chr_bank[r_bank_index] = {wdata[7:1], 1'b0};
                            end else if (r_bank_index < 3'd6) begin
                                n_chr_bank[r_bank_index] = wdata;
                            end else begin
                                n_prg_bank[r_bank_index[0]] = wdata[5:0];
                            end
                        end
                        cbm_pkg::REG_MIRRORING: begin
                            n_mirror = wdata[0];
                        end
                        cbm_pkg::REG_RAM_PROTECT: begin
                            if (r_wram_en) begin
                                n_write_ok = {wdata[6], wdata[4]};
                                n_read_ok  = {wdata[7], wdata[5]};
                            end
                        end
                        cbm_pkg::REG_IRQ_LATCH: begin
                            n_irq_latch = wdata;
                        end
                        cbm_pkg::REG_IRQ_RELOAD: begin
                            n_irq_count = 8'd0;
                        end
                        cbm_pkg::REG_IRQ_DISABLE: begin
                            n_irq_en   = 1'b0;
                            n_irq_pend = 1'b0;
                        end
                        default: begin
                            n_irq_en = 1'b1;
                        end
                    endcase
                end
            end
            cbm_pkg::CMD_VID_READ, cbm_pkg::CMD_VID_WRITE: begin
                // Scanline counter clocked on a filtered rising edge of A12.
                if (a12_rise) begin
                    if (r_filter == 3'd0) begin
                        if (r_irq_count == 8'd0) begin
                            n_irq_count = r_irq_latch;
                        end else begin
                            n_irq_count = r_irq_count - 8'd1;
                            if (r_irq_count == 8'd1 && r_irq_en) begin
                                n_irq_pend = 1'b1;
                            end
                        end
                    end
                    n_filter = cbm_pkg::EDGE_FILTER_TICKS;
                end
                n_last_a12 = vaddr[12];

                if (vaddr[13]) begin
                    o_result.target         = cbm_pkg::TGT_NAMETABLE;
                    o_result.mapped_address = nt_addr;
                end else if (i_word.cmd == cbm_pkg::CMD_VID_READ &&
                             r_chr_kind == cbm_pkg::CHR_KIND_ROM) begin
                    o_result.target         = cbm_pkg::TGT_CHR_ROM;
                    o_result.mapped_address = chr_addr;
                end else if (r_chr_kind == cbm_pkg::CHR_KIND_RAM) begin
                    o_result.target         = cbm_pkg::TGT_CHR_RAM;
                    o_result.mapped_address = chr_addr;
                end
            end
            cbm_pkg::CMD_TICK: begin
                if (r_filter != 3'd0) begin
                    n_filter = r_filter - 3'd1;
                end
            end
            default: begin
            end
        endcase

        o_result.irq_out = n_irq_pend;
    end

    // State registers; bus events update them only when a word is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chr_kind   <= cbm_pkg::CHR_KIND_RESET;
            r_chr_mode   <= 1'b0;
            r_prg_mode   <= 1'b0;
            r_wram_en    <= 1'b0;
            r_bank_index <= 3'd0;
            r_prg_bank   <= '{default: 6'd0};
            r_chr_bank   <= '{default: 8'd0};
            r_mirror     <= 1'b0;
            r_read_ok    <= 2'b00;
            r_write_ok   <= 2'b00;
            r_irq_latch  <= 8'd0;
            r_irq_count  <= 8'd0;
            r_irq_en     <= 1'b0;
            r_filter     <= 3'd0;
            r_irq_pend   <= 1'b0;
            r_last_a12   <= 1'b0;
        end else begin
            r_chr_kind <= n_chr_kind;
            if (i_accept) begin
                r_chr_mode   <= n_chr_mode;
                r_prg_mode   <= n_prg_mode;
                r_wram_en    <= n_wram_en;
                r_bank_index <= n_bank_index;
                r_prg_bank   <= n_prg_bank;
                r_chr_bank   <= n_chr_bank;
                r_mirror     <= n_mirror;
                r_read_ok    <= n_read_ok;
                r_write_ok   <= n_write_ok;
                r_irq_latch  <= n_irq_latch;
                r_irq_count  <= n_irq_count;
                r_irq_en     <= n_irq_en;
                r_filter     <= n_filter;
                r_irq_pend   <= n_irq_pend;
                r_last_a12   <= n_last_a12;
            end
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import cbm_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [2:0] CMD_SPARE      = 3'd7;
    localparam logic [1:0] CHR_KIND_SPARE = 2'd3;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 115;
    localparam int DIR_ROWS     = 25;

    localparam t_out_word NO_MAP = '{TGT_NONE, 19'd0, 1'b0};

    // One directed row: the word, how often it is sent, and a typed result where one is given.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] address;
        logic [7:0]  data;
        logic [3:0]  reps;
        logic        fixed;
        t_out_word   res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    cbm_in_if  in_ch ();
    cbm_out_if out_ch ();
    cbm_cfg_if cfg_ch ();

    cartridge_bank_mapper_scanline_irq dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Mapper state as the checker sees it.
    logic [1:0] chr_kind;
    logic       chr_swap;
    logic       prg_swap;
    logic       wram_on;
    logic [2:0] bank_sel;
    logic [5:0] prg_bank [2];
    logic [7:0] chr_bank [6];
    logic       mirror_bit;
    logic       rd_ok [2];
    logic       wr_ok [2];
    logic [7:0] irq_latch;
    logic [7:0] irq_counter;
    logic       irq_armed;
    logic [2:0] filter_left;
    logic       irq_flag;
    logic       a12_prev;

    t_out_word pending_maps [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        idle_pct = 0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{CMD_PRG_READ,  16'h0000, 8'h00, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_READ,  16'h6FFF, 8'hFF, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_READ,  16'hFFFF, 8'h00, 4'd1, 1'b1, '{TGT_PRG_ROM, 19'h7FFFF, 1'b0}},
        '{CMD_PRG_WRITE, 16'h8000, 8'hE6, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_WRITE, 16'h8001, 8'hFF, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_READ,  16'hC123, 8'h00, 4'd1, 1'b0, NO_MAP},
        '{CMD_PRG_WRITE, 16'hA001, 8'hF0, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_WRITE, 16'h7200, 8'h55, 4'd1, 1'b0, NO_MAP},
        '{CMD_PRG_WRITE, 16'hA001, 8'h20, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_READ,  16'h7300, 8'h00, 4'd1, 1'b1, '{TGT_READ_ZERO, 19'd0, 1'b0}},
        '{CMD_PRG_WRITE, 16'h7000, 8'hAA, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_WRITE, 16'hA000, 8'h01, 4'd1, 1'b1, NO_MAP},
        '{CMD_VID_READ,  16'h2C00, 8'h00, 4'd1, 1'b0, NO_MAP},
        '{CMD_PRG_WRITE, 16'hC000, 8'h01, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_WRITE, 16'hE001, 8'h00, 4'd1, 1'b1, NO_MAP},
        '{CMD_VID_WRITE, 16'h1FFF, 8'h00, 4'd1, 1'b1, NO_MAP},
        '{CMD_VID_READ,  16'h0000, 8'h00, 4'd1, 1'b0, NO_MAP},
        '{CMD_VID_READ,  16'h1000, 8'h00, 4'd1, 1'b0, NO_MAP},
        '{CMD_VID_READ,  16'h0000, 8'h00, 4'd1, 1'b0, NO_MAP},
        '{CMD_TICK,      16'h0000, 8'h00, 4'd6, 1'b0, NO_MAP},
        '{CMD_VID_READ,  16'h1400, 8'h00, 4'd1, 1'b0, NO_MAP},
        '{CMD_PRG_WRITE, 16'hE000, 8'h00, 4'd1, 1'b1, NO_MAP},
        '{CMD_SPARE,     16'h3FFF, 8'hFF, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_WRITE, 16'h8000, 8'h00, 4'd1, 1'b1, NO_MAP},
        '{CMD_PRG_READ,  16'h7000, 8'h00, 4'd1, 1'b1, NO_MAP}
    };

    logic [1:0] phase_kind [PHASES] = '{CHR_KIND_RAM, CHR_KIND_NONE, CHR_KIND_SPARE,
                                        CHR_KIND_ROM, CHR_KIND_RAM, CHR_KIND_ROM};
    int         phase_idle [PHASES] = '{30, 15, 50, 5, 25, 0};

    // Clock: 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic reset_mapper_state();
        chr_kind    = CHR_KIND_RESET;
        chr_swap    = 1'b0;
        prg_swap    = 1'b0;
        wram_on     = 1'b0;
        bank_sel    = 3'd0;
        prg_bank    = '{default: 6'd0};
        chr_bank    = '{default: 8'd0};
        mirror_bit  = 1'b0;
        rd_ok       = '{default: 1'b0};
        wr_ok       = '{default: 1'b0};
        irq_latch   = 8'd0;
        irq_counter = 8'd0;
        irq_armed   = 1'b0;
        filter_left = 3'd0;
        irq_flag    = 1'b0;
        a12_prev    = 1'b0;
    endtask

    // Scanline counter clocked by rising edges of video address bit 12.
    function automatic void clock_scanline(input logic a12);
        if (!a12_prev && a12) begin
            if (filter_left == 3'd0) begin
                if (irq_counter == 8'd0) begin
                    irq_counter = irq_latch;
                end else begin
                    irq_counter = irq_counter - 8'd1;
                    if (irq_counter == 8'd0 && irq_armed)
                        irq_flag = 1'b1;
                end
            end
            filter_left = EDGE_FILTER_TICKS;
        end
        a12_prev = a12;
    endfunction

    function automatic logic [18:0] chr_address(input logic [13:0] v);
        logic [2:0] slot;
        slot = v[12:10];
        if (chr_swap)
            slot[2] = ~slot[2];
        if (!slot[2])
            return {1'b0, chr_bank[{2'b00, slot[1]}], 10'd0} | {8'd0, v[10:0]};
        return {1'b0, chr_bank[slot - 3'd2], v[9:0]};
    endfunction

    function automatic void write_register(input logic [15:0] a, input logic [7:0] d);
        case (a & REG_DECODE_MASK)
            REG_BANK_SELECT: begin
                bank_sel = d[2:0];
                wram_on  = d[5];
                prg_swap = d[6];
                chr_swap = d[7];
                if (!wram_on) begin
                    rd_ok = '{default: 1'b0};
                    wr_ok = '{default: 1'b0};
                end
            end
            REG_BANK_DATA: begin
                if (bank_sel < 3'd2)
                    chr_bank[bank_sel] = d & 8'hFE;
                else if (bank_sel < 3'd6)
                    chr_bank[bank_sel] = d;
                else
                    prg_bank[bank_sel[0]] = d[5:0];
            end
            REG_MIRRORING: mirror_bit = d[0];
            REG_RAM_PROTECT: begin
                if (wram_on) begin
                    wr_ok[0] = d[4];
                    rd_ok[0] = d[5];
                    wr_ok[1] = d[6];
                    rd_ok[1] = d[7];
                end
            end
            REG_IRQ_LATCH: irq_latch = d;
            REG_IRQ_RELOAD: irq_counter = 8'd0;
            REG_IRQ_DISABLE: begin
                irq_armed = 1'b0;
                irq_flag  = 1'b0;
            end
            default: irq_armed = 1'b1;
        endcase
    endfunction

    // Works out the result of one bus event and advances the mapper state.
    function automatic t_out_word map_access(input t_in_word w);
        t_out_word   r;
        logic        half;
        logic [5:0]  bank;
        logic [13:0] v;
        r = NO_MAP;
        case (w.cmd)
            CMD_PRG_READ, CMD_PRG_WRITE: begin
                if (w.address >= 16'h7000 && w.address < 16'h8000) begin
                    half = w.address[9];
                    if (w.cmd == CMD_PRG_READ) begin
                        if (wram_on && (rd_ok[0] || rd_ok[1])) begin
                            if (rd_ok[half]) begin
                                r.target = TGT_PRG_RAM;
                                r.mapped_address = {9'd0, half, w.address[8:0]};
                            end else begin
                                r.target = TGT_READ_ZERO;
                            end
                        end
                    end else if (wram_on && wr_ok[half]) begin
                        r.target = TGT_PRG_RAM;
                        r.mapped_address = {9'd0, half, w.address[8:0]};
                    end
                end else if (w.address[15]) begin
                    if (w.cmd == CMD_PRG_READ) begin
                        case (w.address[14:13])
                            2'd0: bank = prg_swap ? PRG_BANK_SECOND_LAST : prg_bank[0];
                            2'd1: bank = prg_bank[1];
                            2'd2: bank = prg_swap ? prg_bank[0] : PRG_BANK_SECOND_LAST;
                            default: bank = PRG_BANK_LAST;
                        endcase
                        r.target = TGT_PRG_ROM;
                        r.mapped_address = {bank, w.address[12:0]};
                    end else begin
                        write_register(w.address, w.data);
                    end
                end
            end
            CMD_VID_READ, CMD_VID_WRITE: begin
                v = w.address[13:0];
                clock_scanline(v[12]);
                if (v[13]) begin
                    r.target = TGT_NAMETABLE;
                    r.mapped_address = {8'd0, mirror_bit ? v[11] : v[10], v[9:0]};
                end else if (w.cmd == CMD_VID_READ && chr_kind == CHR_KIND_ROM) begin
                    r.target = TGT_CHR_ROM;
                    r.mapped_address = chr_address(v);
                end else if (chr_kind == CHR_KIND_RAM) begin
                    r.target = TGT_CHR_RAM;
                    r.mapped_address = chr_address(v);
                end
            end
            CMD_TICK: begin
                if (filter_left != 3'd0)
                    filter_left = filter_left - 3'd1;
            end
            default: ;
        endcase
        r.irq_out = irq_flag;
        return r;
    endfunction

    // Offers one word, with an occasional idle burst first, and records its result.
    // Valid stays high after acceptance so that back-to-back words need no toggle.
    task automatic send_word(input t_in_word w, input bit fixed, input t_out_word fixed_res);
        t_out_word res;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= w.cmd;
        in_ch.address <= w.address;
        in_ch.data    <= w.data;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        res = map_access(w);
        pending_maps.push_back(fixed ? fixed_res : res);
    endtask

    // Lowers valid and waits until every result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_chr_kind(input logic [1:0] kind);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= kind;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        chr_kind = kind;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_in_word video_word(input logic a12);
        t_in_word w;
        w.cmd = $urandom_range(0, 1) ? CMD_VID_WRITE : CMD_VID_READ;
        w.address = 16'($urandom);
        w.address[12] = a12;
        w.data = 8'($urandom);
        return w;
    endfunction

    // One random stretch: scanline sequences, register writes, program and video accesses, some noise.
    task automatic send_random_burst(inout int sent);
        t_in_word w;
        int       pick;
        int       ticks;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_word(video_word(1'b0), 1'b0, NO_MAP);
            ticks = $urandom_range(0, 8);
            repeat (ticks) begin
                w.cmd = CMD_TICK;
                w.address = 16'($urandom);
                w.data = 8'($urandom);
                send_word(w, 1'b0, NO_MAP);
            end
            send_word(video_word(1'b1), 1'b0, NO_MAP);
            sent += ticks + 2;
        end else if (pick < 45) begin
            w.cmd = CMD_PRG_WRITE;
            w.address = 16'($urandom);
            w.address[15] = 1'b1;
            w.data = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_word(w, 1'b0, NO_MAP);
            sent++;
        end else if (pick < 75) begin
            w.cmd = $urandom_range(0, 1) ? CMD_PRG_WRITE : CMD_PRG_READ;
            case ($urandom_range(0, 3))
                0, 1: w.address = 16'($urandom_range(16'h7000, 16'h7FFF));
                2: w.address = 16'($urandom_range(16'h8000, 16'hFFFF));
                default: w.address = 16'($urandom);
            endcase
            w.data = 8'($urandom);
            send_word(w, 1'b0, NO_MAP);
            sent++;
        end else if (pick < 90) begin
            send_word(video_word($urandom_range(0, 1)), 1'b0, NO_MAP);
            sent++;
        end else begin
            w.cmd = 3'($urandom_range(0, 7));
            w.address = 16'($urandom);
            w.data = 8'($urandom);
            send_word(w, 1'b0, NO_MAP);
            sent++;
        end
    endtask

    // Result side: random stalls, and one long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4 + 1) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Result checker: every accepted word against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_word got;
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.target, out_ch.mapped_address, out_ch.irq_out};
            if (pending_maps.size() == 0) begin
                note_mismatch($sformatf("unexpected result target %0d addr %05h irq %0d",
                                        got.target, got.mapped_address, got.irq_out));
            end else begin
                want = pending_maps.pop_front();
                if (got.target !== want.target || got.mapped_address !== want.mapped_address
                        || got.irq_out !== want.irq_out)
                    note_mismatch($sformatf(
                        "expected target %0d addr %05h irq %0d, got target %0d addr %05h irq %0d",
                        want.target, want.mapped_address, want.irq_out,
                        got.target, got.mapped_address, got.irq_out));
            end
        end
    end

    // Main sequence: reset, directed table, random phases over the memory kinds.
    initial begin : main_seq
        t_in_word w;
        int       sent;
        int       waited;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.cmd     <= CMD_PRG_READ;
        in_ch.address <= 16'd0;
        in_ch.data    <= 8'd0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= CHR_KIND_RESET;
        reset_mapper_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        idle_pct = 20;
        for (int i = 0; i < DIR_ROWS; i++) begin
            w = '{dir_rows[i].cmd, dir_rows[i].address, dir_rows[i].data};
            repeat (dir_rows[i].reps)
                send_word(w, dir_rows[i].fixed, dir_rows[i].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_chr_kind(phase_kind[p]);
            idle_pct = phase_idle[p];
            if (p == 1)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
                send_random_burst(sent);
        end

        // Let the last results come back, then give the verdict.
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_maps.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_maps.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_maps.size()));
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
